// File: sv/lens_ray_deflect_and_bin_macros.svh
// Assertion macros shared by the lens ray deflection block and its divider.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef LENS_RAY_DEFLECT_AND_BIN_MACROS_SVH
`define LENS_RAY_DEFLECT_AND_BIN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRDB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRDB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lrdb_pkg.sv
package lrdb_pkg;

	localparam int MAX_LENSES_DEF = 1024;
	localparam int MAP_SIDE_DEF   = 512;

	// Divider geometry: numerator is mass*|d| shifted up by 16 bits, the
	// denominator is a sum of two squares, the quotient is capped at 2^40.
	localparam int NUM_W      = 80;
	localparam int DEN_W      = 65;
	localparam int QUO_STEPS  = 40;
	localparam int QUO_W      = QUO_STEPS + 1;
	localparam int MUL_W      = 34;
	localparam int ACC_W      = 64;
	localparam int ENTRY_W    = 95;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RAY  = 1'b1;

	localparam logic [1:0] CFG_SHEAR       = 2'd0;
	localparam logic [1:0] CFG_CONVERGENCE = 2'd1;
	localparam logic [1:0] CFG_SOURCE_W    = 2'd2;
	localparam logic [1:0] CFG_LENS_COUNT  = 2'd3;

	typedef struct packed {
		logic               op;
		logic [9:0]         lens_slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [30:0]        lens_weight;
	} lrdb_in_t;

	typedef struct packed {
		logic signed [31:0] bent_x;
		logic signed [31:0] bent_y;
		logic               in_source;
		logic [8:0]         pixel_col;
		logic [8:0]         pixel_row;
		logic               lens_hit;
	} lrdb_out_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_AX1,
		S_AX2,
		S_AY1,
		S_AY2,
		S_AY3,
		S_LRD,
		S_LD1,
		S_LD2,
		S_LD3,
		S_LD4,
		S_LD5,
		S_LD6,
		S_LDIV,
		S_CLAMP,
		S_BCHK,
		S_BIN1,
		S_BIN2,
		S_BDIV,
		S_DONE
	} lrdb_state_t;

endpackage

// File: sv/lens_ray_deflect_and_bin.sv
// Load item: written into the lens store in the accept cycle, no result.
// Ray item: the result is valid after the affine steps, a pass over each lens used, the
// clamp and, unless the ray misses the source square, the binning; the 40-step shared
// divider runs once per lens not at zero distance and once for binning.
// Throughput is one ray at a time; the next item is taken once the result is registered.
// arst_n clears the sequencer, output valid, divider control, config, count and index; the
// payload registers and lens store are not cleared; the store holds garbage until written.
`include "lens_ray_deflect_and_bin_macros.svh"

module lens_ray_deflect_and_bin import lrdb_pkg::*; #(
	parameter int MAX_LENSES = MAX_LENSES_DEF,
	parameter int MAP_SIDE   = MAP_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lrdb_in_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output lrdb_out_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AddrW = (MAX_LENSES > 1) ? $clog2(MAX_LENSES) : 1;
	localparam int CntW  = $clog2(MAX_LENSES + 1);
	localparam logic [8:0] MapLow = 9'(MAP_SIDE);

	// Configuration registers.
	logic signed [31:0] shear_q;
	logic signed [31:0] conv_q;
	logic [30:0]        sw_q;
	logic [10:0]        lcount_q;

	// Sequencer and datapath registers.
	lrdb_state_t              state_q, state_d;
	logic signed [31:0]       x_q, y_q;
	logic [CntW-1:0]          n_q, idx_q;
	logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic signed [32:0]       dx_q, dy_q;
	logic [30:0]              mass_q;
	logic [DEN_W-1:0]         den_q;
	logic [NUM_W-1:0]         numx_q;
	logic                     hit_q;
	logic signed [31:0]       bx_q, by_q;
	logic                     inside_q;
	logic [8:0]               col_q, row_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic                     out_valid_q;
	lrdb_out_t                out_item_q;

	// Combinational signals.
	logic                     in_fire;
	logic                     ram_we;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic                     div_start, div_done;
	logic [NUM_W-1:0]         div_num_a, div_num_b;
	logic [DEN_W-1:0]         div_den;
	logic [QUO_W-1:0]         quo_a, quo_b;
	logic                     out_load;
	logic [31:0]              absdx, absdy;
	logic signed [MUL_W-1:0]  tx, ty, wv;
	logic                     in_box;
	logic                     last_lens;
	logic [CntW-1:0]          n_new;

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// A load item goes straight into the store; slots beyond the store are dropped.
	assign ram_we = in_fire && (in_item.op == OP_LOAD)
		&& (32'(in_item.lens_slot) < 32'(MAX_LENSES));

	lrdb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_LENSES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AddrW'(in_item.lens_slot)),
		.wdata({in_item.pos_x, in_item.pos_y, in_item.lens_weight}),
		.raddr(idx_q[AddrW-1:0]),
		.rdata(ram_rdata)
	);

	lrdb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num_a (div_num_a),
		.num_b (div_num_b),
		.den   (div_den),
		.done  (div_done),
		.quo_a (quo_a),
		.quo_b (quo_b)
	);

	// The lens count is clipped to the depth of the store when a ray starts.
	assign n_new = (32'(lcount_q) > 32'(MAX_LENSES)) ? CntW'(MAX_LENSES) : CntW'(lcount_q);

	// Magnitudes of the ray to lens offsets; they never reach 2^32.
	assign absdx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign absdy = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];

	// Twice the bent position against the full source width avoids halving it.
	assign tx     = MUL_W'(bx_q) <<< 1;
	assign ty     = MUL_W'(by_q) <<< 1;
	assign wv     = signed'(MUL_W'(sw_q));
	assign in_box = (sw_q != '0) && (tx > -wv) && (tx < wv) && (ty > -wv) && (ty < wv);

	assign last_lens = ((idx_q + CntW'(1)) == n_q);

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// One signed multiplier, registered, shared by every product of the ray.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == S_IDLE);
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num_a = numx_q;
		div_num_b = {prod_q[63:0], 16'b0};
		div_den   = den_q;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && in_item.op == OP_RAY) begin
					state_d = S_AX1;
				end
			end
			S_AX1: begin
				mul_a   = MUL_W'(x_q);
				mul_b   = MUL_W'(65536) - MUL_W'(shear_q);
				state_d = S_AX2;
			end
			S_AX2: begin
				mul_a   = MUL_W'(conv_q);
				mul_b   = MUL_W'(x_q);
				state_d = S_AY1;
			end
			S_AY1: begin
				mul_a   = MUL_W'(y_q);
				mul_b   = MUL_W'(65536) + MUL_W'(shear_q);
				state_d = S_AY2;
			end
			S_AY2: begin
				mul_a   = MUL_W'(conv_q);
				mul_b   = MUL_W'(y_q);
				state_d = S_AY3;
			end
			S_AY3: begin
				state_d = (n_q == '0) ? S_CLAMP : S_LRD;
			end
			S_LRD: begin
				state_d = S_LD1;
			end
			S_LD1: begin
				state_d = S_LD2;
			end
			S_LD2: begin
				if (dx_q == '0 && dy_q == '0) begin
					state_d = last_lens ? S_CLAMP : S_LRD;
				end else begin
					mul_a   = MUL_W'(absdx);
					mul_b   = MUL_W'(absdx);
					state_d = S_LD3;
				end
			end
			S_LD3: begin
				mul_a   = MUL_W'(absdy);
				mul_b   = MUL_W'(absdy);
				state_d = S_LD4;
			end
			S_LD4: begin
				mul_a   = MUL_W'(mass_q);
				mul_b   = MUL_W'(absdx);
				state_d = S_LD5;
			end
			S_LD5: begin
				mul_a   = MUL_W'(mass_q);
				mul_b   = MUL_W'(absdy);
				state_d = S_LD6;
			end
			S_LD6: begin
				div_start = 1'b1;
				state_d   = S_LDIV;
			end
			S_LDIV: begin
				if (div_done) begin
					state_d = last_lens ? S_CLAMP : S_LRD;
				end
			end
			S_CLAMP: begin
				state_d = S_BCHK;
			end
			S_BCHK: begin
				if (in_box) begin
					mul_a   = tx + wv;
					mul_b   = MUL_W'(MAP_SIDE);
					state_d = S_BIN1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_BIN1: begin
				mul_a   = ty + wv;
				mul_b   = MUL_W'(MAP_SIDE);
				state_d = S_BIN2;
			end
			S_BIN2: begin
				// Row takes the ceiling, so the divisor minus one is added first.
				div_start = 1'b1;
				div_num_b = NUM_W'(prod_q) + NUM_W'({sw_q, 1'b0}) - NUM_W'(1);
				div_den   = DEN_W'({sw_q, 1'b0});
				state_d   = S_BDIV;
			end
			S_BDIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration writes must arrive only while no ray is in flight; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shear_q  <= '0;
			conv_q   <= '0;
			sw_q     <= 31'd65536;
			lcount_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHEAR:       shear_q  <= cfg_data;
				CFG_CONVERGENCE: conv_q   <= cfg_data;
				CFG_SOURCE_W:    sw_q     <= cfg_data[30:0];
				CFG_LENS_COUNT:  lcount_q <= cfg_data[10:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			n_q   <= '0;
			hit_q <= 1'b0;
		end else begin
			if (in_fire && in_item.op == OP_RAY) begin
				idx_q <= '0;
				n_q   <= n_new;
				hit_q <= 1'b0;
			end
			if (state_q == S_LD2 && dx_q == '0 && dy_q == '0) begin
				hit_q <= 1'b1;
				idx_q <= idx_q + CntW'(1);
			end
			if (state_q == S_LDIV && div_done) begin
				idx_q <= idx_q + CntW'(1);
			end
		end
	end

	// Payload registers of the ray in flight.
	always_ff @(posedge clk) begin
		if (in_fire && in_item.op == OP_RAY) begin
			x_q <= in_item.pos_x;
			y_q <= in_item.pos_y;
		end
		unique case (state_q)
			S_AX2:   acc_x_q <= ACC_W'(prod_q >>> 16);
			S_AY1:   acc_x_q <= acc_x_q - ACC_W'(prod_q >>> 16);
			S_AY2:   acc_y_q <= ACC_W'(prod_q >>> 16);
			S_AY3:   acc_y_q <= acc_y_q - ACC_W'(prod_q >>> 16);
			S_LD1: begin
				dx_q   <= 33'(x_q) - 33'(signed'(ram_rdata[94:63]));
				dy_q   <= 33'(y_q) - 33'(signed'(ram_rdata[62:31]));
				mass_q <= ram_rdata[30:0];
			end
			S_LD3:   den_q  <= DEN_W'(prod_q);
			S_LD4:   den_q  <= den_q + DEN_W'(prod_q);
			S_LD5:   numx_q <= {prod_q[63:0], 16'b0};
			S_LDIV: begin
				if (div_done) begin
					// Each term carries the sign of its offset and is subtracted.
					acc_x_q <= dx_q[32] ? acc_x_q + ACC_W'(quo_a) : acc_x_q - ACC_W'(quo_a);
					acc_y_q <= dy_q[32] ? acc_y_q + ACC_W'(quo_b) : acc_y_q - ACC_W'(quo_b);
				end
			end
			S_CLAMP: begin
				bx_q <= sat32(acc_x_q);
				by_q <= sat32(acc_y_q);
			end
			S_BCHK: begin
				inside_q <= in_box;
				col_q    <= '0;
				row_q    <= '0;
			end
			S_BIN1:  numx_q <= NUM_W'(prod_q);
			S_BDIV: begin
				if (div_done) begin
					col_q <= quo_a[8:0];
					row_q <= MapLow - quo_b[8:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: the finished result waits here while the next item comes in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.bent_x    <= bx_q;
			out_item_q.bent_y    <= by_q;
			out_item_q.in_source <= inside_q;
			out_item_q.pixel_col <= col_q;
			out_item_q.pixel_row <= row_q;
			out_item_q.lens_hit  <= hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`LRDB_ASSERT_NOW(a_ram_we_idle, ram_we, state_q == S_IDLE, "lens store written mid ray")
	`LRDB_ASSERT_NOW(a_idx_bound, 1'b1, idx_q <= n_q, "lens index ran past the count")
	`LRDB_ASSERT_NEXT(a_out_load, out_load, out_valid_q && out_item_q.bent_x == $past(bx_q), "result not registered")
	`LRDB_ASSERT_NOW(a_div_idle_ready, div_start, !in_ready, "divider started while idle")

endmodule

// File: sv/lrdb_ram.sv
module lrdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lrdb_div.sv
`include "lens_ray_deflect_and_bin_macros.svh"

module lrdb_div import lrdb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo_a,
	output logic [QUO_W-1:0] quo_b
);

	localparam int StepW = $clog2(QUO_STEPS);
	localparam logic [StepW-1:0] LastStep = StepW'(QUO_STEPS - 1);
	localparam int TopW = NUM_W - QUO_STEPS;

	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_in [2];
	logic [QUO_W-1:0] quo [2];

	assign num_in[0] = num_a;
	assign num_in[1] = num_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + StepW'(1);
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
		end
	end

	// Two lanes share one denominator. A quotient that would reach 2^40 is
	// caught up front by comparing the top numerator bits with the divisor.
	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [DEN_W-1:0]     rem_q;
		logic [QUO_STEPS-1:0] bits_q;
		logic [QUO_STEPS-1:0] quo_q;
		logic                 cap_q;
		logic [TopW-1:0]      top;
		logic [DEN_W:0]       trial;
		logic [DEN_W:0]       diff;

		assign top   = num_in[l][NUM_W-1:QUO_STEPS];
		assign trial = {rem_q, bits_q[QUO_STEPS-1]};
		assign diff  = trial - {1'b0, den_q};

		always_ff @(posedge clk) begin
			if (start) begin
				cap_q  <= (DEN_W'(top) >= den);
				rem_q  <= DEN_W'(top);
				bits_q <= num_in[l][QUO_STEPS-1:0];
				quo_q  <= '0;
			end else if (busy_q) begin
				if (!diff[DEN_W]) begin
					rem_q <= diff[DEN_W-1:0];
				end else begin
					rem_q <= trial[DEN_W-1:0];
				end
				bits_q <= {bits_q[QUO_STEPS-2:0], 1'b0};
				quo_q  <= {quo_q[QUO_STEPS-2:0], ~diff[DEN_W]};
			end
		end

		assign quo[l] = cap_q ? {1'b1, {QUO_STEPS{1'b0}}} : {1'b0, quo_q};
	end

	assign done  = done_q;
	assign quo_a = quo[0];
	assign quo_b = quo[1];

	`LRDB_ASSERT_NOW(a_div_no_restart, start, !busy_q, "divider started while busy")
	`LRDB_ASSERT_NEXT(a_div_done_after_last, busy_q && cnt_q == LastStep, done_q, "divider missed done")
	`LRDB_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "divider done held too long")

endmodule
